[rtl/rti_pkg.sv]
`default_nettype none
package rti_pkg;

   localparam int COORD_W  = 20;
   localparam int EDGE_W   = COORD_W + 1;
   localparam int VERTEX_W = 3 * COORD_W;
   localparam int EPS_W    = 40;
   localparam int REQ_W    = 6 * COORD_W;
   localparam int DIST_W   = 32;
   localparam int T_FRAC   = 16;

   // cross product terms and results
   localparam int HP_W = COORD_W + EDGE_W;
   localparam int QP_W = 2 * EDGE_W;
   localparam int H_W  = HP_W + 1;
   localparam int Q_W  = QP_W + 1;

   // wide operands are split into an unsigned low and a signed high half
   localparam int H_LO = H_W - EDGE_W;
   localparam int Q_LO = Q_W - EDGE_W;
   localparam int PL_W = EDGE_W + Q_LO + 1;
   localparam int PH_W = 2 * EDGE_W;

   localparam int WIDE_W    = 68;
   localparam int QUO_W     = DIST_W - 1;
   localparam int MAG_SHIFT = QUO_W - T_FRAC;

   localparam int N_DOT   = 4;
   localparam int DOT_DET = 0;
   localparam int DOT_NU  = 1;
   localparam int DOT_NV  = 2;
   localparam int DOT_NT  = 3;
   localparam int LO_SH [N_DOT] = '{H_LO, H_LO, Q_LO, Q_LO};

   localparam int NXT1 [3] = '{1, 2, 0};
   localparam int NXT2 [3] = '{2, 0, 1};

   localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
   localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};

   localparam logic [VERTEX_W-1:0] VERTEX_A_RST = '0;
   localparam logic [VERTEX_W-1:0] VERTEX_B_RST = 60'd1024;
   localparam logic [VERTEX_W-1:0] VERTEX_C_RST = 60'd1073742848;
   localparam logic [EPS_W-1:0]    EPS_RST      = 40'd1;

   typedef enum logic [1:0] {
      CSR_VERTEX_A,
      CSR_VERTEX_B,
      CSR_VERTEX_C,
      CSR_DET_EPS
   } csr_index_type;

   typedef struct packed {
      logic              hit;
      logic              neg_t;
      logic [WIDE_W-1:0] det;
      logic [WIDE_W-1:0] mag;
   } entry_type;

endpackage
`default_nettype wire

[rtl/rti_front.sv]
`default_nettype none
module rti_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rti_pkg::VERTEX_W-1:0]      vertex_a,
   input  logic [rti_pkg::VERTEX_W-1:0]      vertex_b,
   input  logic [rti_pkg::VERTEX_W-1:0]      vertex_c,
   input  logic [rti_pkg::EPS_W-1:0]         det_epsilon,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [rti_pkg::REQ_W-1:0]         in_data,
   input  logic                              q_full,
   output logic                              push,
   output rti_pkg::entry_type                push_data
);

   localparam int NST = 9;

   logic [NST-1:0] v_ff;
   logic           adv;

   logic signed [rti_pkg::COORD_W-1:0] va [3];
   logic signed [rti_pkg::COORD_W-1:0] vb [3];
   logic signed [rti_pkg::COORD_W-1:0] vc [3];
   logic signed [rti_pkg::EDGE_W-1:0]  e1_ff [3];
   logic signed [rti_pkg::EDGE_W-1:0]  e2_ff [3];

   logic signed [rti_pkg::COORD_W-1:0] o0_ff [3];
   logic signed [rti_pkg::COORD_W-1:0] d0_ff [3];
   logic signed [rti_pkg::EDGE_W-1:0]  s1_ff [3];
   logic signed [rti_pkg::COORD_W-1:0] d1_ff [3];
   logic signed [rti_pkg::HP_W-1:0]    pha_ff [3];
   logic signed [rti_pkg::HP_W-1:0]    phb_ff [3];
   logic signed [rti_pkg::QP_W-1:0]    pqa_ff [3];
   logic signed [rti_pkg::QP_W-1:0]    pqb_ff [3];
   logic signed [rti_pkg::EDGE_W-1:0]  s2_ff [3];
   logic signed [rti_pkg::COORD_W-1:0] d2_ff [3];
   logic signed [rti_pkg::H_W-1:0]     h3_ff [3];
   logic signed [rti_pkg::Q_W-1:0]     q3_ff [3];
   logic signed [rti_pkg::EDGE_W-1:0]  s3_ff [3];
   logic signed [rti_pkg::COORD_W-1:0] d3_ff [3];

   logic signed [rti_pkg::H_LO:0]      hlo [3];
   logic signed [rti_pkg::EDGE_W-1:0]  hhi [3];
   logic signed [rti_pkg::Q_LO:0]      qlo [3];
   logic signed [rti_pkg::EDGE_W-1:0]  qhi [3];

   logic signed [rti_pkg::PL_W-1:0]    pl_ff [rti_pkg::N_DOT][3];
   logic signed [rti_pkg::PH_W-1:0]    ph_ff [rti_pkg::N_DOT][3];
   logic signed [rti_pkg::WIDE_W-1:0]  term_ff [rti_pkg::N_DOT][3];
   logic signed [rti_pkg::WIDE_W-1:0]  dot_ff [rti_pkg::N_DOT];
   logic signed [rti_pkg::WIDE_W-1:0]  nrm_ff [rti_pkg::N_DOT];

   logic signed [rti_pkg::WIDE_W-1:0]  det, nu, nv, nt, eps;
   logic                               det_ok, u_ok, v_ok;
   rti_pkg::entry_type                 entry_ff, entry_in;

   assign adv      = !v_ff[NST-1] || !q_full;
   assign in_ready = adv;
   assign push     = v_ff[NST-1] && !q_full;
   assign push_data = entry_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         va[k]  = signed'(vertex_a[k*rti_pkg::COORD_W +: rti_pkg::COORD_W]);
         vb[k]  = signed'(vertex_b[k*rti_pkg::COORD_W +: rti_pkg::COORD_W]);
         vc[k]  = signed'(vertex_c[k*rti_pkg::COORD_W +: rti_pkg::COORD_W]);
         hlo[k] = signed'({1'b0, h3_ff[k][rti_pkg::H_LO-1:0]});
         hhi[k] = signed'(h3_ff[k][rti_pkg::H_W-1:rti_pkg::H_LO]);
         qlo[k] = signed'({1'b0, q3_ff[k][rti_pkg::Q_LO-1:0]});
         qhi[k] = signed'(q3_ff[k][rti_pkg::Q_W-1:rti_pkg::Q_LO]);
      end
   end

   // edges follow the vertex registers, which the user must change only while idle; the block does not enforce it
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         e1_ff[k] <= rti_pkg::EDGE_W'(vb[k]) - rti_pkg::EDGE_W'(va[k]);
         e2_ff[k] <= rti_pkg::EDGE_W'(vc[k]) - rti_pkg::EDGE_W'(va[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            o0_ff[k] <= signed'(in_data[k*rti_pkg::COORD_W +: rti_pkg::COORD_W]);
            d0_ff[k] <= signed'(in_data[(3+k)*rti_pkg::COORD_W +: rti_pkg::COORD_W]);

            s1_ff[k] <= rti_pkg::EDGE_W'(o0_ff[k]) - rti_pkg::EDGE_W'(va[k]);
            d1_ff[k] <= d0_ff[k];

            // h = dir x edge2, q = s x edge1
            pha_ff[k] <= rti_pkg::HP_W'(d1_ff[rti_pkg::NXT1[k]])
                       * rti_pkg::HP_W'(e2_ff[rti_pkg::NXT2[k]]);
            phb_ff[k] <= rti_pkg::HP_W'(d1_ff[rti_pkg::NXT2[k]])
                       * rti_pkg::HP_W'(e2_ff[rti_pkg::NXT1[k]]);
            pqa_ff[k] <= rti_pkg::QP_W'(s1_ff[rti_pkg::NXT1[k]])
                       * rti_pkg::QP_W'(e1_ff[rti_pkg::NXT2[k]]);
            pqb_ff[k] <= rti_pkg::QP_W'(s1_ff[rti_pkg::NXT2[k]])
                       * rti_pkg::QP_W'(e1_ff[rti_pkg::NXT1[k]]);
            s2_ff[k] <= s1_ff[k];
            d2_ff[k] <= d1_ff[k];

            h3_ff[k] <= rti_pkg::H_W'(pha_ff[k]) - rti_pkg::H_W'(phb_ff[k]);
            q3_ff[k] <= rti_pkg::Q_W'(pqa_ff[k]) - rti_pkg::Q_W'(pqb_ff[k]);
            s3_ff[k] <= s2_ff[k];
            d3_ff[k] <= d2_ff[k];

            pl_ff[rti_pkg::DOT_DET][k] <= rti_pkg::PL_W'(e1_ff[k]) * rti_pkg::PL_W'(hlo[k]);
            ph_ff[rti_pkg::DOT_DET][k] <= rti_pkg::PH_W'(e1_ff[k]) * rti_pkg::PH_W'(hhi[k]);
            pl_ff[rti_pkg::DOT_NU][k]  <= rti_pkg::PL_W'(s3_ff[k]) * rti_pkg::PL_W'(hlo[k]);
            ph_ff[rti_pkg::DOT_NU][k]  <= rti_pkg::PH_W'(s3_ff[k]) * rti_pkg::PH_W'(hhi[k]);
            pl_ff[rti_pkg::DOT_NV][k]  <= rti_pkg::PL_W'(qlo[k]) * rti_pkg::PL_W'(d3_ff[k]);
            ph_ff[rti_pkg::DOT_NV][k]  <= rti_pkg::PH_W'(qhi[k]) * rti_pkg::PH_W'(d3_ff[k]);
            pl_ff[rti_pkg::DOT_NT][k]  <= rti_pkg::PL_W'(e2_ff[k]) * rti_pkg::PL_W'(qlo[k]);
            ph_ff[rti_pkg::DOT_NT][k]  <= rti_pkg::PH_W'(e2_ff[k]) * rti_pkg::PH_W'(qhi[k]);
         end

         for (int j = 0; j < rti_pkg::N_DOT; j++) begin
            for (int k = 0; k < 3; k++) begin
               term_ff[j][k] <= (rti_pkg::WIDE_W'(ph_ff[j][k]) <<< rti_pkg::LO_SH[j])
                              + rti_pkg::WIDE_W'(pl_ff[j][k]);
            end
            dot_ff[j] <= term_ff[j][0] + term_ff[j][1] + term_ff[j][2];
            // fold the determinant sign into all numerators
            nrm_ff[j] <= dot_ff[rti_pkg::DOT_DET][rti_pkg::WIDE_W-1] ? -dot_ff[j] : dot_ff[j];
         end

         entry_ff <= entry_in;
      end
   end

   always_comb begin
      det    = nrm_ff[rti_pkg::DOT_DET];
      nu     = nrm_ff[rti_pkg::DOT_NU];
      nv     = nrm_ff[rti_pkg::DOT_NV];
      nt     = nrm_ff[rti_pkg::DOT_NT];
      eps    = signed'(rti_pkg::WIDE_W'(det_epsilon));
      det_ok = (det != '0) && (det >= eps);
      u_ok   = !nu[rti_pkg::WIDE_W-1] && !(nu > det);
      v_ok   = !nv[rti_pkg::WIDE_W-1] && !((nu + nv) > det);
      entry_in.hit   = det_ok && u_ok && v_ok;
      entry_in.neg_t = nt[rti_pkg::WIDE_W-1];
      entry_in.det   = unsigned'(det);
      entry_in.mag   = nt[rti_pkg::WIDE_W-1] ? unsigned'(-nt) : unsigned'(nt);
   end

endmodule
`default_nettype wire

[rtl/rti_queue.sv]
`default_nettype none
module rti_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rti_pkg::entry_type push_data,
   input  logic               pop,
   output rti_pkg::entry_type pop_data,
   output logic               full,
   output logic               empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rti_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, rd_ff;
   logic [CNT_W-1:0]   cnt_ff;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

[rtl/rti_back.sv]
`default_nettype none
module rti_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   output logic                        pop,
   input  rti_pkg::entry_type          pop_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic                        out_hit,
   output logic [rti_pkg::DIST_W-1:0]  out_dist
);

   localparam int QW = rti_pkg::QUO_W;
   localparam int WW = rti_pkg::WIDE_W;

   typedef struct packed {
      logic                            hit;
      logic                            neg_t;
      logic                            ovf;
      logic [WW-1:0]                   det;
      logic [WW-1:0]                   rem;
      logic [QW-1:0]                   quo;
      logic [rti_pkg::MAG_SHIFT-1:0]   mlow;
   } div_stage_type;

   div_stage_type               st_ff [QW+1];
   logic [QW:0]                 sv_ff;
   logic                        adv;
   logic                        out_v_ff, hit_ff;
   logic [rti_pkg::DIST_W-1:0]  dist_ff, dist_in;
   logic [WW-1:0]               mag_hi;
   logic [rti_pkg::DIST_W-1:0]  quo_ext;

   assign adv       = !out_v_ff || out_ready;
   assign pop       = adv && !q_empty;
   assign out_valid = out_v_ff;
   assign out_hit   = hit_ff;
   assign out_dist  = dist_ff;
   assign mag_hi    = pop_data.mag >> rti_pkg::MAG_SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff    <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         sv_ff    <= {sv_ff[QW-1:0], pop};
         out_v_ff <= sv_ff[QW];
      end
   end

   // quotient of at least 2^31 saturates: mag >= det * 2^15
   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0].hit   <= pop_data.hit;
         st_ff[0].neg_t <= pop_data.neg_t;
         st_ff[0].ovf   <= mag_hi >= pop_data.det;
         st_ff[0].det   <= pop_data.det;
         st_ff[0].rem   <= mag_hi;
         st_ff[0].quo   <= '0;
         st_ff[0].mlow  <= pop_data.mag[rti_pkg::MAG_SHIFT-1:0];
      end
   end

   // one restoring division step per stage, quotient MSB first
   for (genvar j = 1; j <= QW; j++) begin : g_div
      localparam int BI = QW - j;
      logic          nbit, ge;
      logic [WW-1:0] rem_sh;

      if (BI >= rti_pkg::T_FRAC) begin : g_num
         assign nbit = st_ff[j-1].mlow[BI - rti_pkg::T_FRAC];
      end else begin : g_zero
         assign nbit = 1'b0;
      end

      assign rem_sh = {st_ff[j-1].rem[WW-2:0], nbit};
      assign ge     = rem_sh >= st_ff[j-1].det;

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[j].hit   <= st_ff[j-1].hit;
            st_ff[j].neg_t <= st_ff[j-1].neg_t;
            st_ff[j].ovf   <= st_ff[j-1].ovf;
            st_ff[j].det   <= st_ff[j-1].det;
            st_ff[j].rem   <= ge ? rem_sh - st_ff[j-1].det : rem_sh;
            st_ff[j].quo   <= {st_ff[j-1].quo[QW-2:0], ge};
            st_ff[j].mlow  <= st_ff[j-1].mlow;
         end
      end
   end

   always_comb begin
      quo_ext = {1'b0, st_ff[QW].quo};
      if (!st_ff[QW].hit) begin
         dist_in = rti_pkg::DIST_MIN;
      end else if (st_ff[QW].ovf) begin
         dist_in = st_ff[QW].neg_t ? rti_pkg::DIST_MIN : rti_pkg::DIST_MAX;
      end else begin
         dist_in = st_ff[QW].neg_t ? -quo_ext : quo_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff  <= st_ff[QW].hit;
         dist_ff <= dist_in;
      end
   end

endmodule
`default_nettype wire

[rtl/ray_triangle_intersect_core.sv]
// A req beat passes 9 front stages, one queue slot and 33 divider and output stages
// on its way to its rsp beat. Throughput: one ray per cycle, set by the fully
// pipelined front and divider, while the queue of QUEUE_DEPTH entries has room; it
// lets the front keep going while rsp is held off.
// Reset clears all valid bits and the queue; the vertex and threshold registers
// return to a unit right triangle in z = 0 with threshold 1.
`default_nettype none
module ray_triangle_intersect_core #(
   parameter int QUEUE_DEPTH = 4   // 2 to 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [rti_pkg::REQ_W-1:0]         req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // distance
   output logic [rti_pkg::DIST_W-1:0]        rsp_tdata,
   // hit
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [rti_pkg::VERTEX_W-1:0]      csr_data
);

   logic [rti_pkg::VERTEX_W-1:0] vertex_a_ff, vertex_b_ff, vertex_c_ff;
   logic [rti_pkg::EPS_W-1:0]    det_eps_ff;
   logic                         push, pop, q_full, q_empty;
   rti_pkg::entry_type           push_data, pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_ff <= rti_pkg::VERTEX_A_RST;
         vertex_b_ff <= rti_pkg::VERTEX_B_RST;
         vertex_c_ff <= rti_pkg::VERTEX_C_RST;
         det_eps_ff  <= rti_pkg::EPS_RST;
      end else if (csr_valid) begin
         case (rti_pkg::csr_index_type'(csr_index))
            rti_pkg::CSR_VERTEX_A: vertex_a_ff <= csr_data;
            rti_pkg::CSR_VERTEX_B: vertex_b_ff <= csr_data;
            rti_pkg::CSR_VERTEX_C: vertex_c_ff <= csr_data;
            rti_pkg::CSR_DET_EPS:  det_eps_ff  <= csr_data[rti_pkg::EPS_W-1:0];
            default: ;
         endcase
      end
   end

   rti_front u_front (
      .clock       (clock),
      .reset       (reset),
      .vertex_a    (vertex_a_ff),
      .vertex_b    (vertex_b_ff),
      .vertex_c    (vertex_c_ff),
      .det_epsilon (det_eps_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_data     (req_tdata),
      .q_full      (q_full),
      .push        (push),
      .push_data   (push_data)
   );

   rti_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   rti_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .pop       (pop),
      .pop_data  (pop_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (rsp_tuser),
      .out_dist  (rsp_tdata)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> !pop)
      else $error("pop from empty queue");

   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == rti_pkg::DIST_MIN))
      else $error("miss without sentinel distance");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result right after reset");

endmodule
`default_nettype wire

[tb/sv/ray_triangle_intersect_core_test.sv]
`timescale 1ns / 1ps
`default_nettype none
module ray_triangle_intersect_core_test;

   typedef struct {
      bit          hit;
      logic [31:0] distance;
   } isect_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [rti_pkg::REQ_W-1:0]    req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [rti_pkg::DIST_W-1:0]   rsp_tdata;
   logic                         rsp_tuser;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [1:0]                   csr_index = '0;
   logic [rti_pkg::VERTEX_W-1:0] csr_data = '0;

   ray_triangle_intersect_core dut (.*);

   always #5 clock = ~clock;

   // shadow of the triangle registers
   logic [rti_pkg::VERTEX_W-1:0] tri_a = rti_pkg::VERTEX_A_RST;
   logic [rti_pkg::VERTEX_W-1:0] tri_b = rti_pkg::VERTEX_B_RST;
   logic [rti_pkg::VERTEX_W-1:0] tri_c = rti_pkg::VERTEX_C_RST;
   logic [rti_pkg::EPS_W-1:0]    eps_reg = rti_pkg::EPS_RST;

   logic [rti_pkg::REQ_W-1:0] pending_rays[$];
   isect_type                 expected_isects[$];
   int                        gap_max = 18, stall_max = 18;
   int                        gap_left = 0, stall_left = 0;
   bit                        req_taken = 0;
   bit                        failed = 0;

   function automatic logic signed [127:0] sx(input logic [19:0] v);
      logic signed [127:0] w;
      w = $signed(v);
      return w;
   endfunction

   function automatic isect_type intersect_ray(input logic [rti_pkg::REQ_W-1:0] ray);
      logic signed [127:0] pa[3], pb[3], pc[3], o[3], d[3];
      logic signed [127:0] e1[3], e2[3], s[3], h[3], q[3];
      logic signed [127:0] det, nu, nv, nt, mag, quo;
      bit                  neg_t;
      isect_type           r;
      r.hit = 0;
      r.distance = 32'h8000_0000;
      for (int k = 0; k < 3; k++) begin
         pa[k] = sx(tri_a[k*20 +: 20]);
         pb[k] = sx(tri_b[k*20 +: 20]);
         pc[k] = sx(tri_c[k*20 +: 20]);
         o[k]  = sx(ray[k*20 +: 20]);
         d[k]  = sx(ray[(k+3)*20 +: 20]);
         e1[k] = pb[k] - pa[k];
         e2[k] = pc[k] - pa[k];
         s[k]  = o[k] - pa[k];
      end
      for (int k = 0; k < 3; k++) begin
         h[k] = d[(k+1)%3] * e2[(k+2)%3] - d[(k+2)%3] * e2[(k+1)%3];
         q[k] = s[(k+1)%3] * e1[(k+2)%3] - s[(k+2)%3] * e1[(k+1)%3];
      end
      det = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
      nu  = s[0]*h[0] + s[1]*h[1] + s[2]*h[2];
      nv  = q[0]*d[0] + q[1]*d[1] + q[2]*d[2];
      nt  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
      if (det < 0) begin
         det = -det; nu = -nu; nv = -nv; nt = -nt;
      end
      if (det == 0 || det < $signed({88'd0, eps_reg})) return r;
      if (nu < 0 || nu > det) return r;
      if (nv < 0 || nu + nv > det) return r;
      neg_t = nt < 0;
      mag = (neg_t ? -nt : nt) <<< rti_pkg::T_FRAC;
      quo = mag / det;
      r.hit = 1;
      if (!neg_t) r.distance = (quo > 128'sh7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
      else r.distance = (quo >= 128'sh8000_0000) ? 32'h8000_0000 : -quo[31:0];
      return r;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_rays.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_rays[0];
            gap_left = $urandom_range(0, gap_max);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         expected_isects.push_back(intersect_ray(req_tdata));
         void'(pending_rays.pop_front());
      end
   end

   // response side: random back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_tvalid && rsp_tready) stall_left = $urandom_range(0, stall_max);
      end
   end

   always @(posedge clock) begin
      isect_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_isects.size() == 0) begin
            $display("%0t: unexpected rsp beat hit=%0b distance=%h", $time, rsp_tuser,
                     rsp_tdata);
            failed = 1;
         end else begin
            e = expected_isects.pop_front();
            if (rsp_tuser !== e.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, e.hit, rsp_tuser);
               failed = 1;
            end
            if (rsp_tdata !== e.distance) begin
               $display("%0t: distance expected %h actual %h", $time, e.distance,
                        rsp_tdata);
               failed = 1;
            end
         end
      end
   end

   task automatic csr_write(input rti_pkg::csr_index_type idx,
                            input logic [rti_pkg::VERTEX_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rti_pkg::CSR_VERTEX_A: tri_a = val;
         rti_pkg::CSR_VERTEX_B: tri_b = val;
         rti_pkg::CSR_VERTEX_C: tri_c = val;
         rti_pkg::CSR_DET_EPS:  eps_reg = val[rti_pkg::EPS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [59:0] pt(input int x, input int y, input int z);
      return {z[19:0], y[19:0], x[19:0]};
   endfunction

   function automatic logic [rti_pkg::REQ_W-1:0] ray(input int ox, oy, oz, dx, dy, dz);
      return {pt(dx, dy, dz), pt(ox, oy, oz)};
   endfunction

   function automatic int rnd_coord(input int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   // mostly rays aimed at a point inside or near the current triangle
   function automatic logic [rti_pkg::REQ_W-1:0] random_ray();
      int u, v, o[3], t;
      int mode = $urandom_range(0, 3);
      logic [rti_pkg::REQ_W-1:0] r;
      if (mode == 0) begin
         r = rti_pkg::REQ_W'({$urandom, $urandom, $urandom, $urandom});
         return r;
      end
      u = $urandom_range(0, 1100);
      v = $urandom_range(0, 1100 - u);
      if (mode == 3) v = rnd_coord(200);
      for (int k = 0; k < 3; k++) begin
         o[k] = rnd_coord(200000);
         t = int'(sx(tri_a[k*20 +: 20]));
         t = t + (int'(sx(tri_b[k*20 +: 20])) - t) / 1024 * u
               + (int'(sx(tri_c[k*20 +: 20])) - t) / 1024 * v;
         r[(k+3)*20 +: 20] = 20'(t - o[k]);
         r[k*20 +: 20] = 20'(o[k]);
      end
      return r;
   endfunction

   task automatic run_phase();
      wait (pending_rays.size() == 0 && expected_isects.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_triangle(input int lim);
      csr_write(rti_pkg::CSR_VERTEX_A, pt(rnd_coord(lim), rnd_coord(lim), rnd_coord(lim)));
      csr_write(rti_pkg::CSR_VERTEX_B, pt(rnd_coord(lim), rnd_coord(lim), rnd_coord(lim)));
      csr_write(rti_pkg::CSR_VERTEX_C, pt(rnd_coord(lim), rnd_coord(lim), rnd_coord(lim)));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset triangle: (0,0,0) (1,0,0) (1,1,0)
      pending_rays.push_back(ray(256, 128, 1024, 0, 0, -1024));       // interior
      pending_rays.push_back(ray(0, 0, 1024, 0, 0, -1024));           // on a vertex
      pending_rays.push_back(ray(1024, 512, 1024, 0, 0, -1024));      // on the far edge
      pending_rays.push_back(ray(512, 512, 1024, 0, 0, -1024));       // on the diagonal
      pending_rays.push_back(ray(-256, 128, 1024, 0, 0, -1024));      // outside, u < 0
      pending_rays.push_back(ray(2048, 128, 1024, 0, 0, -1024));      // outside, u > 1
      pending_rays.push_back(ray(256, -128, 1024, 0, 0, -1024));      // outside, v < 0
      pending_rays.push_back(ray(256, 512, 1024, 0, 0, -1024));       // outside, u < 0
      pending_rays.push_back(ray(256, 128, 1024, 1024, 0, 0));        // parallel
      pending_rays.push_back(ray(256, 128, 1024, 0, 0, 1024));        // behind origin
      pending_rays.push_back(ray(256, 128, 524287, 0, 0, -1));        // t saturates high
      pending_rays.push_back(ray(256, 128, -524288, 0, 0, -1));       // t saturates low
      pending_rays.push_back(ray(256, 128, 1024, 0, 0, 0));           // zero direction
      pending_rays.push_back(ray(524287, 524287, 524287, 524287, 524287, 524287));
      pending_rays.push_back(ray(-524288, -524288, -524288, -524288, -524288, -524288));
      pending_rays.push_back(ray(524287, -524288, 524287, -524288, 524287, -524288));
      pending_rays.push_back(ray(0, 0, 0, 1, 1, -1));
      pending_rays.push_back(ray(300, 100, 7, 0, 0, -524288));
      for (int i = 0; i < 70; i++) pending_rays.push_back(random_ray());
      run_phase();

      // zero threshold, no idling
      gap_max = 0;
      stall_max = 0;
      random_triangle(200000);
      csr_write(rti_pkg::CSR_DET_EPS, '0);
      for (int i = 0; i < 120; i++) pending_rays.push_back(random_ray());
      pending_rays.push_back(ray(0, 0, 0, 0, 0, 0));
      run_phase();

      // extreme vertices, maximum threshold
      gap_max = 18;
      stall_max = 18;
      csr_write(rti_pkg::CSR_VERTEX_A, pt(524287, 524287, 524287));
      csr_write(rti_pkg::CSR_VERTEX_B, pt(-524288, -524288, -524288));
      csr_write(rti_pkg::CSR_VERTEX_C, pt(524287, -524288, 0));
      csr_write(rti_pkg::CSR_DET_EPS, {20'd0, 40'hFF_FFFF_FFFF});
      for (int i = 0; i < 40; i++) pending_rays.push_back(random_ray());
      run_phase();
      csr_write(rti_pkg::CSR_DET_EPS, rti_pkg::VERTEX_W'(1));
      for (int i = 0; i < 30; i++) pending_rays.push_back(random_ray());
      run_phase();

      // random triangles and thresholds
      for (int p = 0; p < 6; p++) begin
         gap_max = (p % 3 == 2) ? 0 : 18;
         stall_max = (p % 2 == 1) ? 0 : 18;
         random_triangle(p < 3 ? 200000 : 3000);
         csr_write(rti_pkg::CSR_DET_EPS,
                   {20'd0, 8'($urandom_range(0, (1 << (p + 3)) - 1)), $urandom});
         for (int i = 0; i < 50; i++) pending_rays.push_back(random_ray());
         run_phase();
      end

      if (!failed) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire

[ray_triangle_intersect_core.f]
rtl/rti_pkg.sv
rtl/rti_front.sv
rtl/rti_queue.sv
rtl/rti_back.sv
rtl/ray_triangle_intersect_core.sv
tb/sv/ray_triangle_intersect_core_test.sv
